// ----- rtl/epoch_to_calendar_date_defines.svh -----
// assertion macros shared by the epoch-to-calendar rtl
// no dependencies; included by the modules that carry checks
`ifndef EPOCH_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATE_DEFINES_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define E2C_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("e2c check failed");
// antecedent implies consequent in the next cycle
`define E2C_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("e2c check failed");
`else
`define E2C_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define E2C_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/e2c_pkg.sv -----
// types, constants and calendar helpers for the epoch-to-calendar converter
// no dependencies; used by e2c_cmpsub and epoch_to_calendar_date
package e2c_pkg;

   localparam int EPOCH_W = 32;
   localparam int YEAR_W  = 12;
   localparam int DAYS_W  = 16;
   localparam int MUL_W   = 26;

   // reciprocal division: q = ((n >> PRE) * RECIP) >> SHIFT, exact over each operand range
   // seconds to days, 86400 = 675 << 7, input up to 2^32 - 1
   localparam int               DAY_PRE    = 7;
   localparam int               DAY_SHIFT  = 35;
   localparam logic [MUL_W-1:0] DAY_RECIP  = 26'd50903317;
   // seconds of day to hours, 3600 = 225 << 4
   localparam int               HOUR_PRE   = 4;
   localparam int               HOUR_SHIFT = 21;
   localparam logic [MUL_W-1:0] HOUR_RECIP = 26'd9321;
   // seconds of hour to minutes, 60 = 15 << 2
   localparam int               MIN_PRE    = 2;
   localparam int               MIN_SHIFT  = 14;
   localparam logic [MUL_W-1:0] MIN_RECIP  = 26'd1093;
   // day count to weeks
   localparam int               WDAY_SHIFT = 19;
   localparam logic [MUL_W-1:0] WDAY_RECIP = 26'd74899;

   localparam logic [MUL_W-1:0] SEC_PER_DAY  = 26'd86400;
   localparam logic [MUL_W-1:0] SEC_PER_HOUR = 26'd3600;
   localparam logic [MUL_W-1:0] SEC_PER_MIN  = 26'd60;
   localparam logic [MUL_W-1:0] DAYS_PER_WK  = 26'd7;

   localparam logic [YEAR_W-1:0] BASE_YEAR    = 12'd1970;
   localparam logic [YEAR_W-1:0] CENTURY_SKIP = 12'd2100;
   localparam logic [DAYS_W-1:0] THURSDAY     = 16'd4;
   localparam logic [3:0]        DECEMBER_IDX = 4'd11;
   localparam logic [3:0]        FEBRUARY_IDX = 4'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAYS,
      ST_TOD,
      ST_HOUR,
      ST_HREM,
      ST_MIN,
      ST_MREM,
      ST_WDAY,
      ST_WREM,
      ST_YEAR,
      ST_MONTH
   } state_type;

   // result of the shared compare/subtract unit
   typedef struct packed {
      logic                ge;
      logic [EPOCH_W-1:0]  diff;
   } sub_res_type;

   // leap rule over the reachable years 1970..2106: 2000 is leap, 2100 is not
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      return (y[1:0] == 2'b00) && (y != CENTURY_SKIP);
   endfunction

   function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
      return is_leap(y) ? 9'd366 : 9'd365;
   endfunction

   // month index 0 is january
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         FEBRUARY_IDX: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/e2c_cmpsub.sv -----
// shared compare/subtract unit: difference and greater-or-equal flag
// depends on e2c_pkg
module e2c_cmpsub
   import e2c_pkg::*;
(
   input  logic [EPOCH_W-1:0] opa,
   input  logic [EPOCH_W-1:0] opb,
   output sub_res_type        res
);

   logic [EPOCH_W:0] wide_diff;

   // borrow out of the top bit means opa < opb
   assign wide_diff = {1'b0, opa} - {1'b0, opb};
   assign res.diff  = wide_diff[EPOCH_W-1:0];
   assign res.ge    = ~wide_diff[EPOCH_W];

endmodule

// ----- rtl/epoch_to_calendar_date.sv -----
// Channel   Ports                               Handshake
// request   start, busy, req_epoch_seconds      taken when start & !busy
// response  rsp_valid, rsp_year .. rsp_weekday  one-cycle strobe, no stall
//
// A request runs the fixed steps, then one year step per year walked plus one and
// one month step per month walked plus one; rsp_valid is registered after the last one.
// Eight fixed steps split the count by reciprocal multiplication on one shared
// multiplier, each quotient followed by its remainder through the compare/subtract
// unit; then that unit walks one whole year past 1970 per cycle and one month per cycle.
// busy drops in the cycle rsp_valid is high, so a new request can be taken then.
// Reset is synchronous; the receiver cannot stall.
// depends on e2c_pkg, e2c_cmpsub and epoch_to_calendar_date_defines.svh
`include "epoch_to_calendar_date_defines.svh"

module epoch_to_calendar_date
   import e2c_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [EPOCH_W-1:0]  req_epoch_seconds,
   output logic                rsp_valid,
   output logic [YEAR_W-1:0]   rsp_year,
   output logic [3:0]          rsp_month,
   output logic [4:0]          rsp_day_of_month,
   output logic [4:0]          rsp_hour,
   output logic [5:0]          rsp_minute,
   output logic [5:0]          rsp_second,
   output logic [2:0]          rsp_weekday
);

   state_type            state_ff, state_in;
   logic [EPOCH_W-1:0]   rem_ff, rem_in;
   logic [DAYS_W-1:0]    quo_ff, quo_in;
   logic [DAYS_W-1:0]    days_ff, days_in;
   logic [3:0]           mon_ff, mon_in;
   logic                 valid_ff, valid_in;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [3:0]           month_ff, month_in;
   logic [4:0]           mday_ff, mday_in;
   logic [4:0]           hour_ff, hour_in;
   logic [5:0]           minute_ff, minute_in;
   logic [5:0]           second_ff, second_in;
   logic [2:0]           wday_ff, wday_in;

   logic [MUL_W-1:0]     mul_a;
   logic [MUL_W-1:0]     mul_b;
   logic [2*MUL_W-1:0]   mul_p;
   logic [EPOCH_W-1:0]   opb;
   sub_res_type          sub;
   logic                 month_stop;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DAYS: begin
            mul_a = MUL_W'(rem_ff >> DAY_PRE);
            mul_b = DAY_RECIP;
         end
         ST_TOD: begin
            mul_a = MUL_W'(days_ff);
            mul_b = SEC_PER_DAY;
         end
         ST_HOUR: begin
            mul_a = MUL_W'(rem_ff >> HOUR_PRE);
            mul_b = HOUR_RECIP;
         end
         ST_HREM: begin
            mul_a = MUL_W'(hour_ff);
            mul_b = SEC_PER_HOUR;
         end
         ST_MIN: begin
            mul_a = MUL_W'(rem_ff >> MIN_PRE);
            mul_b = MIN_RECIP;
         end
         ST_MREM: begin
            mul_a = MUL_W'(minute_ff);
            mul_b = SEC_PER_MIN;
         end
         ST_WDAY: begin
            mul_a = MUL_W'(rem_ff);
            mul_b = WDAY_RECIP;
         end
         ST_WREM: begin
            mul_a = MUL_W'(quo_ff);
            mul_b = DAYS_PER_WK;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

   // operand select for the shared compare/subtract unit
   always_comb begin
      case (state_ff)
         ST_TOD, ST_HREM, ST_MREM, ST_WREM: opb = mul_p[EPOCH_W-1:0];
         ST_YEAR:  opb = EPOCH_W'(year_len(year_ff));
         ST_MONTH: opb = EPOCH_W'(month_len(mon_ff, is_leap(year_ff)));
         default:  opb = '0;
      endcase
   end

   e2c_cmpsub u_cmpsub (
      .opa (rem_ff),
      .opb (opb),
      .res (sub)
   );

   assign month_stop = !sub.ge || (mon_ff == DECEMBER_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_DAYS;
         ST_DAYS:  state_in = ST_TOD;
         ST_TOD:   state_in = ST_HOUR;
         ST_HOUR:  state_in = ST_HREM;
         ST_HREM:  state_in = ST_MIN;
         ST_MIN:   state_in = ST_MREM;
         ST_MREM:  state_in = ST_WDAY;
         ST_WDAY:  state_in = ST_WREM;
         ST_WREM:  state_in = ST_YEAR;
         ST_YEAR:  if (!sub.ge) state_in = ST_MONTH;
         ST_MONTH: if (month_stop) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and result updates
   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      days_in   = days_ff;
      mon_in    = mon_ff;
      valid_in  = 1'b0;
      year_in   = year_ff;
      month_in  = month_ff;
      mday_in   = mday_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      wday_in   = wday_ff;
      case (state_ff)
         ST_IDLE: begin
            rem_in = req_epoch_seconds;
         end
         ST_DAYS: begin
            days_in = mul_p[DAY_SHIFT +: DAYS_W];
         end
         ST_TOD: begin
            // seconds within the day
            rem_in = sub.diff;
         end
         ST_HOUR: begin
            hour_in = mul_p[HOUR_SHIFT +: 5];
         end
         ST_HREM: begin
            // seconds within the hour
            rem_in = sub.diff;
         end
         ST_MIN: begin
            minute_in = mul_p[MIN_SHIFT +: 6];
         end
         ST_MREM: begin
            second_in = sub.diff[5:0];
            rem_in    = EPOCH_W'(days_ff) + EPOCH_W'(THURSDAY);
         end
         ST_WDAY: begin
            quo_in = mul_p[WDAY_SHIFT +: DAYS_W];
         end
         ST_WREM: begin
            wday_in = sub.diff[2:0];
            rem_in  = EPOCH_W'(days_ff);
            year_in = BASE_YEAR;
         end
         ST_YEAR: begin
            // walk whole years while the remaining days cover one
            if (sub.ge) begin
               rem_in  = sub.diff;
               year_in = year_ff + 12'd1;
            end else begin
               mon_in = '0;
            end
         end
         ST_MONTH: begin
            if (month_stop) begin
               month_in = mon_ff + 4'd1;
               mday_in  = rem_ff[4:0] + 5'd1;
               valid_in = 1'b1;
            end else begin
               rem_in = sub.diff;
               mon_in = mon_ff + 4'd1;
            end
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      days_ff   <= days_in;
      mon_ff    <= mon_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      mday_ff   <= mday_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      wday_ff   <= wday_in;
   end

   // outputs
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_year         = year_ff;
   assign rsp_month        = month_ff;
   assign rsp_day_of_month = mday_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;
   assign rsp_weekday      = wday_ff;

   // checks
   `E2C_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `E2C_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy && $past(busy))
   `E2C_ASSERT_SAME(a_year_range, clock, reset, state_ff == ST_YEAR, year_ff <= 12'd2106)
   `E2C_ASSERT_SAME(a_month_range, clock, reset, rsp_valid, rsp_month >= 4'd1 && rsp_month <= 4'd12)
   `E2C_ASSERT_SAME(a_tod_range, clock, reset, rsp_valid, rsp_hour < 5'd24 && rsp_minute < 6'd60)

endmodule
